### sv/ptt_pkg.sv
// Shared constants and types for the periodic timer table.
`default_nettype none
package ptt_pkg;

  localparam int NUM_SLOTS  = 16;
  localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam int FUNC_W   = 2;
  localparam int ID_W     = 16;
  localparam int IVL_W    = 24;
  localparam int ELA_W    = 25;
  localparam int RES_W    = 10;
  localparam int MIN_W    = 16;
  localparam int STATUS_W = 2;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_KILL = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  localparam logic KIND_FIRE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic REG_RESOLUTION   = 1'b0;
  localparam logic REG_MIN_INTERVAL = 1'b1;

  localparam logic [RES_W-1:0] RES_RESET = 10'd10;
  localparam logic [MIN_W-1:0] MIN_RESET = 16'd100;
  localparam logic [ELA_W-1:0] ELA_MAX   = {ELA_W{1'b1}};

  typedef struct packed {
    logic                  load;
    logic                  scan;
    logic                  finish;
    logic [SLOT_IDX_W-1:0] idx;
  } ptt_cmd_t;

  typedef struct packed {
    logic scan_needed;
  } ptt_sts_t;

endpackage
`default_nettype wire

### sv/ptt_ctrl.sv
// Sequencer for the periodic timer table: accept, slot scan, finish.
`default_nettype none
module ptt_ctrl
  import ptt_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire ptt_sts_t sts_i,
  output ptt_cmd_t      cmd_o,
  output logic          busy_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  localparam logic [SLOT_IDX_W-1:0] LAST_IDX = SLOT_IDX_W'(NUM_SLOTS - 1);

  logic [1:0]            state_q, state_d;
  logic [SLOT_IDX_W-1:0] idx_q, idx_d;

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    cmd_o.load    = 1'b0;
    cmd_o.scan    = 1'b0;
    cmd_o.finish  = 1'b0;
    cmd_o.idx     = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          idx_d      = '0;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts_i.scan_needed) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.scan = 1'b1;
          if (idx_q == LAST_IDX) begin
            state_d = S_FINISH;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule
`default_nettype wire

### sv/ptt_dp.sv
// Datapath for the periodic timer table: slot store, match search, tick update, results.
`default_nettype none
module ptt_dp
  import ptt_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ptt_cmd_t            cmd_i,
  output ptt_sts_t                 sts_o,
  input  wire logic [RES_W-1:0]    resolution_i,
  input  wire logic [MIN_W-1:0]    min_interval_i,
  input  wire logic [FUNC_W-1:0]   func_i,
  input  wire logic [ID_W-1:0]     timer_id_i,
  input  wire logic [IVL_W-1:0]    interval_ms_i,
  output logic                     strobe_o,
  output logic                     kind_o,
  output logic [ID_W-1:0]          fired_id_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic                     last_o
);

  logic [FUNC_W-1:0] func_q;
  logic [ID_W-1:0]   id_q;
  logic [IVL_W-1:0]  ivl_q;

  logic                  match_vld_q, free_vld_q;
  logic [SLOT_IDX_W-1:0] match_idx_q, free_idx_q;

  logic [NUM_SLOTS-1:0] slot_valid_q;
  logic [ID_W-1:0]      slot_id_q  [NUM_SLOTS];
  logic [IVL_W-1:0]     slot_ivl_q [NUM_SLOTS];
  logic [ELA_W-1:0]     slot_ela_q [NUM_SLOTS];

  logic                  strobe_q, kind_q, last_q;
  logic [ID_W-1:0]       fired_id_q;
  logic [STATUS_W-1:0]   status_q;

  logic                  rd_valid;
  logic [ID_W-1:0]       rd_id;
  logic [IVL_W-1:0]      rd_ivl;
  logic [ELA_W-1:0]      rd_ela;
  logic                  id_hit;
  logic [ELA_W:0]        ela_sum;
  logic [ELA_W-1:0]      ela_sat, ela_new;
  logic                  tick_fire;
  logic                  is_tick, is_set, is_kill;
  logic                  ivl_short;
  logic                  set_write, kill_clear;
  logic [SLOT_IDX_W-1:0] set_idx;
  logic [STATUS_W-1:0]   fin_status;

  assign rd_valid = slot_valid_q[cmd_i.idx];
  assign rd_id    = slot_id_q[cmd_i.idx];
  assign rd_ivl   = slot_ivl_q[cmd_i.idx];
  assign rd_ela   = slot_ela_q[cmd_i.idx];
  assign id_hit   = rd_valid && (rd_id == id_q);

  assign is_set    = (func_q == FUNC_SET);
  assign is_kill   = (func_q == FUNC_KILL);
  assign is_tick   = (func_q == FUNC_TICK);
  assign ivl_short = (ivl_q < IVL_W'(min_interval_i));

  assign sts_o.scan_needed = is_tick || is_kill || (is_set && !ivl_short);

  // Saturating add of one tick, then subtract the period on a fire.
  assign ela_sum   = {1'b0, rd_ela} + (ELA_W + 1)'(resolution_i);
  assign ela_sat   = ela_sum[ELA_W] ? ELA_MAX : ela_sum[ELA_W-1:0];
  assign tick_fire = (ela_sat >= ELA_W'(rd_ivl));
  assign ela_new   = tick_fire ? (ela_sat - ELA_W'(rd_ivl)) : ela_sat;

  assign set_idx    = match_vld_q ? match_idx_q : free_idx_q;
  assign set_write  = cmd_i.finish && is_set && !ivl_short && (match_vld_q || free_vld_q);
  assign kill_clear = cmd_i.finish && is_kill && match_vld_q;

  always_comb begin
    priority if (is_set && ivl_short) begin
      fin_status = ST_SHORT;
    end else if (is_set && !match_vld_q && !free_vld_q) begin
      fin_status = ST_FULL;
    end else if (is_kill && !match_vld_q) begin
      fin_status = ST_NOT_FOUND;
    end else begin
      fin_status = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      id_q   <= timer_id_i;
      ivl_q  <= interval_ms_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_vld_q <= 1'b0;
      free_vld_q  <= 1'b0;
    end else if (cmd_i.load) begin
      match_vld_q <= 1'b0;
      free_vld_q  <= 1'b0;
    end else if (cmd_i.scan && !is_tick) begin
      if (id_hit && !match_vld_q) begin
        match_vld_q <= 1'b1;
      end
      if (!rd_valid && !free_vld_q) begin
        free_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && !is_tick) begin
      if (id_hit && !match_vld_q) begin
        match_idx_q <= cmd_i.idx;
      end
      if (!rd_valid && !free_vld_q) begin
        free_idx_q <= cmd_i.idx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
    end else if (set_write) begin
      slot_valid_q[set_idx] <= 1'b1;
    end else if (kill_clear) begin
      slot_valid_q[match_idx_q] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (set_write) begin
      slot_id_q[set_idx]  <= id_q;
      slot_ivl_q[set_idx] <= ivl_q;
      slot_ela_q[set_idx] <= '0;
    end else if (cmd_i.scan && is_tick && rd_valid) begin
      slot_ela_q[cmd_i.idx] <= ela_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.finish || (cmd_i.scan && is_tick && rd_valid && tick_fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      kind_q     <= KIND_STATUS;
      fired_id_q <= '0;
      status_q   <= fin_status;
      last_q     <= 1'b1;
    end else begin
      kind_q     <= KIND_FIRE;
      fired_id_q <= rd_id;
      status_q   <= ST_OK;
      last_q     <= 1'b0;
    end
  end

  assign strobe_o   = strobe_q;
  assign kind_o     = kind_q;
  assign fired_id_o = fired_id_q;
  assign status_o   = status_q;
  assign last_o     = last_q;

endmodule
`default_nettype wire

### sv/periodic_timer_table.sv
// Top level of the periodic timer table with its configuration registers.
// Sequence: on start the request is loaded, then every slot is scanned in turn (none for an
// unused code or a short set), then the finish step gives the registered status result.
// A new start is taken only while idle; busy_o is high while scanning or finishing.
// Fires stream out one per cycle during a tick scan; the receiver cannot stall.
// Reset: asynchronous, active low; clears all slots and loads the register defaults.
`default_nettype none
module periodic_timer_table
  import ptt_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire logic [FUNC_W-1:0]   func_i,
  input  wire logic [ID_W-1:0]     timer_id_i,
  input  wire logic [IVL_W-1:0]    interval_ms_i,
  output logic                     strobe_o,
  output logic                     kind_o,
  output logic [ID_W-1:0]          fired_id_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic                     last_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  logic [RES_W-1:0] resolution_q;
  logic [MIN_W-1:0] min_interval_q;
  logic             cfg_wr;
  ptt_cmd_t         cmd;
  ptt_sts_t         sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resolution_q   <= RES_RESET;
      min_interval_q <= MIN_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_RESOLUTION:   resolution_q   <= pwdata[RES_W-1:0];
        REG_MIN_INTERVAL: min_interval_q <= pwdata[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_RESOLUTION:   prdata = DATA_W'(resolution_q);
      REG_MIN_INTERVAL: prdata = DATA_W'(min_interval_q);
      default:          prdata = '0;
    endcase
  end

  ptt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  ptt_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .resolution_i   (resolution_q),
    .min_interval_i (min_interval_q),
    .func_i         (func_i),
    .timer_id_i     (timer_id_i),
    .interval_ms_i  (interval_ms_i),
    .strobe_o       (strobe_o),
    .kind_o         (kind_o),
    .fired_id_o     (fired_id_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

endmodule
`default_nettype wire
